[hdl/palette_flash_fade_engine_unit_macros.svh]
// Assertion macros used by the controller RTL file of the palette effect engine.
`ifndef PALETTE_FLASH_FADE_ENGINE_UNIT_MACROS_SVH
`define PALETTE_FLASH_FADE_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PFFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pffe assertion failed");
`define PFFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pffe assertion failed");
`else
`define PFFE_ASSERT_SAME(label, ante, cons)
`define PFFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/pffe_pkg.sv]
package pffe_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int PALETTE_SIZE = 512;

  localparam int SLOT_IW = $clog2(SLOT_COUNT);
  localparam int PAL_AW  = $clog2(PALETTE_SIZE);

  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int IDX_W   = 9;
  localparam int COLOR_W = 15;
  localparam int CNT_W   = 8;
  localparam int HALF_W  = 6;
  localparam int CHAN_W  = 5;
  localparam int CHAN_N  = 3;
  localparam int CHAN_MAX = (1 << CHAN_W) - 1;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_WR_ORIG  = 3'd0;
  localparam cmd_t CMD_WR_SHOWN = 3'd1;
  localparam cmd_t CMD_RD_SHOWN = 3'd2;
  localparam cmd_t CMD_ADD      = 3'd3;
  localparam cmd_t CMD_REMOVE   = 3'd4;
  localparam cmd_t CMD_FADE     = 3'd5;
  localparam cmd_t CMD_FLASH    = 3'd6;
  localparam cmd_t CMD_START    = 3'd7;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_OUT  = 2'd1;
  localparam phase_t PH_BACK = 2'd2;

  typedef struct packed {
    logic               we;
    logic [PAL_AW-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [PAL_AW-1:0]  raddr;
  } pal_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               status;
    logic               half_done;
  } res_t;

  function automatic logic [PAL_AW-1:0] pal_wrap(input logic [IDX_W-1:0] v);
    logic [IDX_W:0] w;
    w = {1'b0, v};
    if (w >= (IDX_W+1)'(PALETTE_SIZE)) begin
      w = w - (IDX_W+1)'(PALETTE_SIZE);
    end
    return w[PAL_AW-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] cur,
                                                  input logic [CHAN_W-1:0] orig,
                                                  input logic back,
                                                  input logic down);
    logic [CHAN_W-1:0] res;
    res = cur;
    if (!back) begin
      if (down) begin
        if (cur != '0) res = cur - 1'b1;
      end else begin
        if (cur != CHAN_W'(CHAN_MAX)) res = cur + 1'b1;
      end
    end else begin
      if (down) begin
        if (cur > orig) res = cur - 1'b1;
      end else begin
        if (cur < orig) res = cur + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [COLOR_W-1:0] fade_color(input logic [COLOR_W-1:0] cur,
                                                    input logic [COLOR_W-1:0] orig,
                                                    input logic back,
                                                    input logic down);
    logic [COLOR_W-1:0] res;
    res = '0;
    for (int ch = 0; ch < CHAN_N; ch++) begin
      res[ch*CHAN_W +: CHAN_W] = fade_chan(cur[ch*CHAN_W +: CHAN_W],
                                           orig[ch*CHAN_W +: CHAN_W], back, down);
    end
    return res;
  endfunction

endpackage

[hdl/pffe_ram.sv]
module pffe_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/pffe_ctrl.sv]
`include "palette_flash_fade_engine_unit_macros.svh"

module pffe_ctrl
  import pffe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [IDX_W-1:0]   in_color_index,
  input  logic [COLOR_W-1:0] in_color,
  input  logic [IDX_W-1:0]   in_first_color,
  input  logic [CNT_W-1:0]   in_color_count,
  input  logic [HALF_W-1:0]  in_fade_cycles,
  input  logic               in_start_darker,
  input  logic               in_clear_all,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] out_read_color,
  output logic               out_status,
  output logic               out_half_done,
  output pal_req_t           sh_req,
  output pal_req_t           or_req,
  input  logic [COLOR_W-1:0] sh_rdata,
  input  logic [COLOR_W-1:0] or_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDW  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  res_t       pend_r, pend_nxt;
  res_t       out_r;
  logic       out_valid_r;
  logic       out_load;

  logic [SLOT_COUNT-1:0] in_use_r;
  logic [SLOT_COUNT-1:0] down_r;
  phase_t                phase_r [SLOT_COUNT];
  logic [HALF_W-1:0]     step_r  [SLOT_COUNT];
  logic [HALF_W-1:0]     half_r  [SLOT_COUNT];
  logic [COLOR_W-1:0]    flash_r [SLOT_COUNT];
  logic [PAL_AW-1:0]     first_r [SLOT_COUNT];
  logic [CNT_W-1:0]      count_r [SLOT_COUNT];

  logic [SLOT_IW-1:0] cur_slot_r;
  logic [PAL_AW-1:0]  addr_r, addr_nxt;
  logic [PAL_AW-1:0]  wr_addr_r;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               rd_vld_r, rd_vld_nxt;
  logic               run_flash_r;
  phase_t             run_phase_r;
  logic               run_down_r;
  logic [COLOR_W-1:0] run_col_r;
  logic [HALF_W-1:0]  run_step_r;
  logic [HALF_W-1:0]  run_half_r;

  logic               acc;
  logic [SLOT_IW-1:0] sidx;
  logic               ok;
  logic               active;
  logic               do_add, do_remove, do_clear, do_start, start_run, fin_step;
  logic               half_end;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign sidx     = in_slot[SLOT_IW-1:0];
  assign ok       = (SLOT_W+1)'(in_slot) < (SLOT_W+1)'(SLOT_COUNT);
  assign active   = in_use_r[sidx] && (phase_r[sidx] == PH_OUT || phase_r[sidx] == PH_BACK);
  assign half_end = run_flash_r || (run_step_r == run_half_r);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    addr_nxt   = addr_r;
    iss_nxt    = iss_r;
    rd_vld_nxt = 1'b0;
    sh_req     = '0;
    or_req     = '0;
    do_add     = 1'b0;
    do_remove  = 1'b0;
    do_clear   = 1'b0;
    do_start   = 1'b0;
    start_run  = 1'b0;
    fin_step   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          pend_nxt  = '0;
          state_nxt = ST_FIN;
          case (in_command)
            CMD_WR_ORIG: begin
              or_req.we    = 1'b1;
              or_req.waddr = pal_wrap(in_color_index);
              or_req.wdata = in_color;
            end
            CMD_WR_SHOWN: begin
              sh_req.we    = 1'b1;
              sh_req.waddr = pal_wrap(in_color_index);
              sh_req.wdata = in_color;
            end
            CMD_RD_SHOWN: begin
              sh_req.re    = 1'b1;
              sh_req.raddr = pal_wrap(in_color_index);
              state_nxt    = ST_RDW;
            end
            CMD_ADD: begin
              if (!ok || in_use_r[sidx]) pend_nxt.status = 1'b1;
              else do_add = 1'b1;
            end
            CMD_REMOVE: begin
              if (!ok || !in_use_r[sidx]) pend_nxt.status = 1'b1;
              else do_remove = 1'b1;
            end
            CMD_FADE, CMD_FLASH: begin
              if (!ok || !active) begin
                pend_nxt.status = 1'b1;
              end else begin
                start_run = 1'b1;
                addr_nxt  = first_r[sidx];
                iss_nxt   = '0;
                state_nxt = ST_RUN;
              end
            end
            CMD_START: begin
              if (in_clear_all) do_clear = 1'b1;
              else if (!ok || !in_use_r[sidx]) pend_nxt.status = 1'b1;
              else if (phase_r[sidx] == PH_IDLE) do_start = 1'b1;
            end
            default: begin
              pend_nxt.status = 1'b1;
            end
          endcase
        end
      end
      ST_RDW: begin
        pend_nxt.read_color = sh_rdata;
        state_nxt           = ST_FIN;
      end
      ST_RUN: begin
        if (iss_r != cnt_r) begin
          sh_req.re    = 1'b1;
          sh_req.raddr = addr_r;
          or_req.re    = 1'b1;
          or_req.raddr = addr_r;
          rd_vld_nxt   = 1'b1;
          iss_nxt      = iss_r + 1'b1;
          addr_nxt     = (addr_r == PAL_AW'(PALETTE_SIZE - 1)) ? '0 : addr_r + 1'b1;
        end
        if (rd_vld_r) begin
          sh_req.we    = 1'b1;
          sh_req.waddr = wr_addr_r;
          if (run_flash_r) begin
            sh_req.wdata = (run_phase_r == PH_OUT) ? run_col_r : or_rdata;
          end else begin
            sh_req.wdata = fade_color(sh_rdata, or_rdata, run_phase_r == PH_BACK, run_down_r);
          end
        end
        if (iss_r == cnt_r && !rd_vld_r) begin
          fin_step           = 1'b1;
          pend_nxt.half_done = half_end;
          state_nxt          = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (start_run) cnt_r <= count_r[sidx];
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    addr_r    <= addr_nxt;
    wr_addr_r <= addr_r;
    if (out_load) out_r <= pend_r;
    if (start_run) begin
      cur_slot_r  <= sidx;
      run_flash_r <= (in_command == CMD_FLASH);
      run_phase_r <= phase_r[sidx];
      run_down_r  <= down_r[sidx];
      run_col_r   <= flash_r[sidx];
      run_step_r  <= step_r[sidx];
      run_half_r  <= half_r[sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) phase_r[i] <= PH_IDLE;
    end else begin
      if (do_clear) begin
        in_use_r <= '0;
        for (int i = 0; i < SLOT_COUNT; i++) phase_r[i] <= PH_IDLE;
      end
      if (do_add) begin
        in_use_r[sidx] <= 1'b1;
        phase_r[sidx]  <= PH_IDLE;
      end
      if (do_remove) begin
        in_use_r[sidx] <= 1'b0;
        phase_r[sidx]  <= PH_IDLE;
      end
      if (do_start) phase_r[sidx] <= PH_OUT;
      if (fin_step && half_end) begin
        phase_r[cur_slot_r] <= (run_phase_r == PH_OUT) ? PH_BACK : PH_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      step_r[sidx]  <= '0;
      down_r[sidx]  <= in_start_darker;
      flash_r[sidx] <= in_color;
      first_r[sidx] <= pal_wrap(in_first_color);
      count_r[sidx] <= in_color_count;
      half_r[sidx]  <= in_fade_cycles;
    end
    if (fin_step && !run_flash_r) begin
      if (half_end) begin
        step_r[cur_slot_r] <= '0;
        down_r[cur_slot_r] <= !run_down_r;
      end else begin
        step_r[cur_slot_r] <= run_step_r + 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_color = out_r.read_color;
  assign out_status     = out_r.status;
  assign out_half_done  = out_r.half_done;

  // The read pipeline must be drained before the next beat can be taken.
  `PFFE_ASSERT_SAME(a_idle_drained, state_r == ST_IDLE, !rd_vld_r)
  `PFFE_ASSERT_SAME(a_issue_bound, state_r == ST_RUN, iss_r <= cnt_r)
  `PFFE_ASSERT_NEXT(a_fin_holds, state_r == ST_FIN && out_valid_r && !out_ready,
                    state_r == ST_FIN)
  `PFFE_ASSERT_SAME(a_run_write, sh_req.we && state_r == ST_RUN, rd_vld_r)

endmodule

[hdl/palette_flash_fade_engine_unit.sv]
// Each input beat yields one result beat through the result and output registers; a palette
// read first passes the RAM read register, and an accepted step first walks its range.
// A step walks its range through the palette RAMs, one entry issued per cycle.
// The next input beat is taken once the result moves to the output register, so only one
// beat is in flight at a time and a stalled output also holds off the input.
// Synchronous active-low reset clears all effect slots; the palette RAMs are not cleared.
module palette_flash_fade_engine_unit
  import pffe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [IDX_W-1:0]   in_color_index,
  input  logic [COLOR_W-1:0] in_color,
  input  logic [IDX_W-1:0]   in_first_color,
  input  logic [CNT_W-1:0]   in_color_count,
  input  logic [HALF_W-1:0]  in_fade_cycles,
  input  logic               in_start_darker,
  input  logic               in_clear_all,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] out_read_color,
  output logic               out_status,
  output logic               out_half_done
);

  pal_req_t           sh_req;
  pal_req_t           or_req;
  logic [COLOR_W-1:0] sh_rdata;
  logic [COLOR_W-1:0] or_rdata;

  pffe_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_color_index (in_color_index),
    .in_color       (in_color),
    .in_first_color (in_first_color),
    .in_color_count (in_color_count),
    .in_fade_cycles (in_fade_cycles),
    .in_start_darker(in_start_darker),
    .in_clear_all   (in_clear_all),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_color (out_read_color),
    .out_status     (out_status),
    .out_half_done  (out_half_done),
    .sh_req         (sh_req),
    .or_req         (or_req),
    .sh_rdata       (sh_rdata),
    .or_rdata       (or_rdata)
  );

  pffe_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_shown_ram (
    .clk  (clk),
    .we   (sh_req.we),
    .waddr(sh_req.waddr),
    .wdata(sh_req.wdata),
    .re   (sh_req.re),
    .raddr(sh_req.raddr),
    .rdata(sh_rdata)
  );

  pffe_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_orig_ram (
    .clk  (clk),
    .we   (or_req.we),
    .waddr(or_req.waddr),
    .wdata(or_req.wdata),
    .re   (or_req.re),
    .raddr(or_req.raddr),
    .rdata(or_rdata)
  );

endmodule
